[sv/cbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the cascaded balance controller
// Sequencer states, multiplier-accumulator control word, register indexes and
// the fixed-point limits used by the datapath.
// ----------------------------------------------------------------------------
package cbp_pkg;

	localparam int GAIN_W  = 24;   // signed Q8.16 gains
	localparam int CFG_W   = 24;   // widest configuration register
	localparam int MUL_B_W = 33;   // second multiplier operand
	localparam int PROD_W  = GAIN_W + MUL_B_W;
	localparam int ACC_W   = 72;   // accumulator, holds a 24 by 48 bit product
	localparam int HI_SHIFT = 24;  // weight of the upper half of the tilt integral
	localparam int ERR_W   = 25;   // tilt error, Q8
	localparam int CHG_W   = 26;   // tilt error change, Q8

	localparam logic signed [ACC_W-1:0] PROD_LIM  = 72'sd9007199254740992;
	localparam logic signed [ACC_W-1:0] DRIVE_LIM = 72'sd1677721600;
	localparam logic signed [15:0]      DRIVE_MAX = 16'sd25600;
	localparam logic signed [ERR_W-1:0] RESET_BAND = 25'sd1280;

	typedef enum logic [2:0] {
		REG_ANGLE_SETPOINT,
		REG_TILT_KP,
		REG_TILT_KI,
		REG_TILT_KD,
		REG_POSITION_KP,
		REG_VELOCITY_KI,
		REG_VELOCITY_KD,
		REG_ACCEL_GAIN
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VEL,
		ST_UPD,
		ST_M0,
		ST_M1,
		ST_SINT,
		ST_O2,
		ST_O3,
		ST_O4,
		ST_OFF,
		ST_ERR,
		ST_INT,
		ST_I0,
		ST_I1,
		ST_I2,
		ST_I3,
		ST_I4,
		ST_I5,
		ST_DRV
	} state_t;

	typedef enum logic [1:0] {
		ADD_ZERO,
		ADD_PROD,
		ADD_PROD_SH24,
		ADD_VALUE
	} add_sel_t;

	typedef struct packed {
		logic                       mul_en;
		logic signed [GAIN_W-1:0]   mul_a;
		logic signed [MUL_B_W-1:0]  mul_b;
		logic                       clr;
		add_sel_t                   add_sel;
		logic signed [ACC_W-1:0]    value;
	} mac_ctl_t;

endpackage
`default_nettype wire

[sv/cbp_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_mac: shared multiplier-accumulator
// A registered 24 by 33 bit signed multiplier feeding a 72 bit accumulator.
// The product is added in the cycle after it is issued.
// ----------------------------------------------------------------------------
module cbp_mac (
	input  wire logic                                  clk,
	input  wire cbp_pkg::mac_ctl_t                     ctl,
	output logic signed [cbp_pkg::ACC_W-1:0]           acc
);

	localparam int AW = cbp_pkg::ACC_W;
	localparam int PW = cbp_pkg::PROD_W;
	localparam int SH = cbp_pkg::HI_SHIFT;

	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] addend;
	logic signed [AW-1:0] base;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= $signed(ctl.mul_a) * $signed(ctl.mul_b);
		end
		acc_q <= base + addend;
	end

	// The shifted form only carries the upper half of the tilt integral, whose
	// product fits in the low AW-SH bits.
	always_comb begin
		base = ctl.clr ? '0 : acc_q;
		case (ctl.add_sel)
			cbp_pkg::ADD_PROD:      addend = {{(AW-PW){prod_q[PW-1]}}, prod_q};
			cbp_pkg::ADD_PROD_SH24: addend = {prod_q[AW-SH-1:0], {SH{1'b0}}};
			cbp_pkg::ADD_VALUE:     addend = ctl.value;
			default:                addend = '0;
		endcase
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

[sv/cascaded_balance_pid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_balance_pid: cascaded position and tilt balance controller
// Outer position loop forms a tilt offset; inner tilt PID forms a clamped drive.
// All products run through one shared multiplier-accumulator.
// ----------------------------------------------------------------------------
// A taken sample runs from ST_VEL to ST_DRV; the result beat is loaded from
// ST_DRV. No new sample is taken until the 18-step sequence that drives the
// single multiplier-accumulator is back in ST_IDLE; in_stall is high meanwhile.
// A pending result beat does not block the next sample until its final step.
// Reset (asynchronous, active low) loads the default gains and zeroes the loop state.
module cascaded_balance_pid #(
	parameter int UPDATE_PERIOD_MS = 100
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [11:0] tilt_sample,
	input  wire logic signed [31:0] wheel_position,
	input  wire logic [31:0]        now_ms,
	input  wire logic signed [7:0]  target_velocity,
	input  wire logic signed [31:0] goal_position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      drive_command,
	output logic signed [23:0]      tilt_offset
);

	localparam int AW  = cbp_pkg::ACC_W;
	localparam int GW  = cbp_pkg::GAIN_W;
	localparam int BW  = cbp_pkg::MUL_B_W;
	localparam int EW  = cbp_pkg::ERR_W;
	localparam int CW  = cbp_pkg::CHG_W;
	localparam logic [31:0] PERIOD = 32'(UPDATE_PERIOD_MS);

	localparam logic signed [AW-1:0] SI_MAX  = 72'sd2147483647;
	localparam logic signed [AW-1:0] SI_MIN  = -72'sd2147483648;
	localparam logic signed [AW-1:0] OFF_MAX = 72'sd8388607;
	localparam logic signed [AW-1:0] OFF_MIN = -72'sd8388608;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
		logic signed [31:0] r;
		if (x[32] != x[31]) begin
			r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [11:0]   setpoint_q;
	logic signed [GW-1:0] tilt_kp_q, tilt_ki_q, tilt_kd_q;
	logic signed [GW-1:0] position_kp_q, velocity_ki_q, velocity_kd_q, accel_gain_q;

	// Sample registers.
	logic signed [11:0] tilt_q;
	logic signed [31:0] pos_q, tpos_q;
	logic [31:0]        now_q;
	logic signed [7:0]  tvel_q;

	// Controller state.
	logic [31:0]          outer_last_q, inner_last_q;
	logic signed [31:0]   last_pos_q, prev_speed_q, speed_err_q, accel_q, speed_int_q;
	logic signed [47:0]   tilt_int_q;
	logic signed [EW-1:0] tilt_last_err_q;
	logic signed [CW-1:0] tilt_chg_q;

	// Working registers.
	cbp_pkg::state_t      state_q, state_d;
	logic                 outer_do_q, inner_do_q;
	logic signed [31:0]   vel_q;
	logic signed [32:0]   perr_q;
	logic signed [23:0]   offset_q;
	logic signed [EW-1:0] err_q;

	logic                 out_valid_q;
	logic signed [15:0]   drive_q;
	logic signed [23:0]   toff_q;

	cbp_pkg::mac_ctl_t    mac_ctl;
	logic signed [AW-1:0] acc;
	logic                 out_load;

	logic signed [AW-1:0] tr_sum, tr_val, off_sh, drv_c, prod_clamp;
	logic signed [31:0]   sint_next, drv_r;
	logic signed [23:0]   offset_next;
	logic signed [48:0]   tint_sum;
	logic signed [47:0]   tint_next;
	logic                 in_band;

	cbp_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.acc (acc)
	);

	// Datapath helpers on the accumulator and tilt error.
	always_comb begin
		tr_sum = acc + (acc[AW-1] ? 72'sd65535 : 72'sd0);
		tr_val = tr_sum >>> 16;
		if (tr_val > SI_MAX) begin
			sint_next = 32'sh7FFF_FFFF;
		end else if (tr_val < SI_MIN) begin
			sint_next = 32'sh8000_0000;
		end else begin
			sint_next = tr_val[31:0];
		end

		// The rounding constant is already in the accumulator.
		off_sh = acc >>> 8;
		if (off_sh > OFF_MAX) begin
			offset_next = 24'sh7F_FFFF;
		end else if (off_sh < OFF_MIN) begin
			offset_next = 24'sh80_0000;
		end else begin
			offset_next = off_sh[23:0];
		end

		if (acc > cbp_pkg::PROD_LIM) begin
			prod_clamp = cbp_pkg::PROD_LIM;
		end else if (acc < -cbp_pkg::PROD_LIM) begin
			prod_clamp = -cbp_pkg::PROD_LIM;
		end else begin
			prod_clamp = acc;
		end

		if (acc > cbp_pkg::DRIVE_LIM) begin
			drv_c = cbp_pkg::DRIVE_LIM;
		end else if (acc < -cbp_pkg::DRIVE_LIM) begin
			drv_c = -cbp_pkg::DRIVE_LIM;
		end else begin
			drv_c = acc;
		end
		drv_r = $signed(drv_c[31:0]) + 32'sd32768;

		in_band = (err_q < cbp_pkg::RESET_BAND) && (err_q > -cbp_pkg::RESET_BAND);
		tint_sum = {tilt_int_q[47], tilt_int_q} + {{(49-EW){err_q[EW-1]}}, err_q};
		if (!in_band) begin
			tint_next = '0;
		end else if (tint_sum[48] != tint_sum[47]) begin
			tint_next = tint_sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end else begin
			tint_next = tint_sum[47:0];
		end
	end

	// Sequencer: next state and multiplier-accumulator control.
	always_comb begin
		state_d  = state_q;
		mac_ctl  = '0;
		out_load = 1'b0;
		unique case (state_q)
			cbp_pkg::ST_IDLE: begin
				if (in_valid) state_d = cbp_pkg::ST_VEL;
			end
			cbp_pkg::ST_VEL: state_d = cbp_pkg::ST_UPD;
			cbp_pkg::ST_UPD: state_d = cbp_pkg::ST_M0;
			cbp_pkg::ST_M0: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = velocity_ki_q;
				mac_ctl.mul_b   = {speed_err_q[31], speed_err_q};
				mac_ctl.clr     = 1'b1;
				mac_ctl.add_sel = cbp_pkg::ADD_VALUE;
				mac_ctl.value   = {{(AW-48){speed_int_q[31]}}, speed_int_q, 16'h0000};
				state_d = cbp_pkg::ST_M1;
			end
			cbp_pkg::ST_M1: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = position_kp_q;
				mac_ctl.mul_b   = perr_q;
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_SINT;
			end
			cbp_pkg::ST_SINT: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = velocity_kd_q;
				mac_ctl.mul_b   = {speed_err_q[31], speed_err_q};
				mac_ctl.clr     = 1'b1;
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_O2;
			end
			cbp_pkg::ST_O2: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = accel_gain_q;
				mac_ctl.mul_b   = {accel_q[31], accel_q};
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_O3;
			end
			cbp_pkg::ST_O3: begin
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_O4;
			end
			cbp_pkg::ST_O4: begin
				// Velocity integral in Q16 plus the half step for rounding to Q8.
				mac_ctl.add_sel = cbp_pkg::ADD_VALUE;
				mac_ctl.value   = {{(AW-48){speed_int_q[31]}}, speed_int_q, 16'h0080};
				state_d = cbp_pkg::ST_OFF;
			end
			cbp_pkg::ST_OFF: state_d = cbp_pkg::ST_ERR;
			cbp_pkg::ST_ERR: state_d = cbp_pkg::ST_INT;
			cbp_pkg::ST_INT: state_d = cbp_pkg::ST_I0;
			cbp_pkg::ST_I0: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.mul_a  = tilt_ki_q;
				mac_ctl.mul_b  = {{(BW-24){1'b0}}, tilt_int_q[23:0]};
				state_d = cbp_pkg::ST_I1;
			end
			cbp_pkg::ST_I1: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = tilt_ki_q;
				mac_ctl.mul_b   = {{(BW-24){tilt_int_q[47]}}, tilt_int_q[47:24]};
				mac_ctl.clr     = 1'b1;
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_I2;
			end
			cbp_pkg::ST_I2: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = tilt_kp_q;
				mac_ctl.mul_b   = {{(BW-EW){err_q[EW-1]}}, err_q};
				mac_ctl.add_sel = cbp_pkg::ADD_PROD_SH24;
				state_d = cbp_pkg::ST_I3;
			end
			cbp_pkg::ST_I3: begin
				// The integral term saturates on its own before the other terms join.
				mac_ctl.clr     = 1'b1;
				mac_ctl.add_sel = cbp_pkg::ADD_VALUE;
				mac_ctl.value   = prod_clamp;
				state_d = cbp_pkg::ST_I4;
			end
			cbp_pkg::ST_I4: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.mul_a   = tilt_kd_q;
				mac_ctl.mul_b   = {{(BW-CW){tilt_chg_q[CW-1]}}, tilt_chg_q};
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_I5;
			end
			cbp_pkg::ST_I5: begin
				mac_ctl.add_sel = cbp_pkg::ADD_PROD;
				state_d = cbp_pkg::ST_DRV;
			end
			cbp_pkg::ST_DRV: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = cbp_pkg::ST_IDLE;
				end
			end
			default: state_d = cbp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q    <= '0;
			tilt_kp_q     <= 24'sd183501;
			tilt_ki_q     <= '0;
			tilt_kd_q     <= '0;
			position_kp_q <= 24'sd393;
			velocity_ki_q <= 24'sd66;
			velocity_kd_q <= 24'sd98304;
			accel_gain_q  <= 24'sd32768;
		end else if (cfg_write) begin
			unique case (cbp_pkg::reg_idx_t'(cfg_index))
				cbp_pkg::REG_ANGLE_SETPOINT: setpoint_q    <= cfg_data[11:0];
				cbp_pkg::REG_TILT_KP:        tilt_kp_q     <= cfg_data;
				cbp_pkg::REG_TILT_KI:        tilt_ki_q     <= cfg_data;
				cbp_pkg::REG_TILT_KD:        tilt_kd_q     <= cfg_data;
				cbp_pkg::REG_POSITION_KP:    position_kp_q <= cfg_data;
				cbp_pkg::REG_VELOCITY_KI:    velocity_ki_q <= cfg_data;
				cbp_pkg::REG_VELOCITY_KD:    velocity_kd_q <= cfg_data;
				cbp_pkg::REG_ACCEL_GAIN:     accel_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample capture and working values.
	always_ff @(posedge clk) begin
		if (state_q == cbp_pkg::ST_IDLE && in_valid) begin
			tilt_q <= tilt_sample;
			pos_q  <= wheel_position;
			now_q  <= now_ms;
			tvel_q <= target_velocity;
			tpos_q <= goal_position;
		end
		if (state_q == cbp_pkg::ST_VEL) begin
			vel_q <= sat32({pos_q[31], pos_q} - {last_pos_q[31], last_pos_q});
		end
		if (state_q == cbp_pkg::ST_UPD) begin
			perr_q <= {tpos_q[31], tpos_q} - {pos_q[31], pos_q};
		end
		if (state_q == cbp_pkg::ST_OFF) begin
			offset_q <= offset_next;
		end
		if (state_q == cbp_pkg::ST_ERR) begin
			err_q <= {{(EW-20){setpoint_q[11]}}, setpoint_q, 8'h00}
				+ {{(EW-24){offset_q[23]}}, offset_q}
				- {{(EW-20){tilt_q[11]}}, tilt_q, 8'h00};
		end
		if (out_load) begin
			drive_q <= drv_r[31:16];
			toff_q  <= offset_q;
		end
	end

	// Controller state and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_do_q      <= 1'b0;
			inner_do_q      <= 1'b0;
			outer_last_q    <= '0;
			inner_last_q    <= '0;
			last_pos_q      <= '0;
			prev_speed_q    <= '0;
			speed_err_q     <= '0;
			accel_q         <= '0;
			speed_int_q     <= '0;
			tilt_int_q      <= '0;
			tilt_last_err_q <= '0;
			tilt_chg_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (state_q == cbp_pkg::ST_VEL) begin
				outer_do_q <= (now_q - outer_last_q) > PERIOD;
				inner_do_q <= (now_q - inner_last_q) > PERIOD;
			end
			if (state_q == cbp_pkg::ST_UPD && outer_do_q) begin
				accel_q      <= sat32({vel_q[31], vel_q} - {prev_speed_q[31], prev_speed_q});
				speed_err_q  <= sat32({{25{tvel_q[7]}}, tvel_q} - {vel_q[31], vel_q});
				last_pos_q   <= pos_q;
				prev_speed_q <= vel_q;
				outer_last_q <= now_q;
			end
			if (state_q == cbp_pkg::ST_SINT && outer_do_q) begin
				speed_int_q <= sint_next;
			end
			if (state_q == cbp_pkg::ST_INT) begin
				tilt_int_q <= tint_next;
				if (inner_do_q) begin
					tilt_chg_q      <= {err_q[EW-1], err_q} - {tilt_last_err_q[EW-1], tilt_last_err_q};
					tilt_last_err_q <= err_q;
					inner_last_q    <= now_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall      = (state_q != cbp_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign drive_command = drive_q;
	assign tilt_offset   = toff_q;

	// A taken sample keeps the input side closed for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while the sequencer was busy");

	// The drive never leaves the plus or minus 100 percent band.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_command <= cbp_pkg::DRIVE_MAX
			&& drive_command >= -cbp_pkg::DRIVE_MAX))
		else $error("drive command outside its limit");

	// A tilt error outside the band clears the integral.
	a_int_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbp_pkg::ST_INT && !in_band) |=> (tilt_int_q == '0))
		else $error("tilt integral not cleared outside the band");

endmodule
`default_nettype wire

[test/cascaded_balance_pid_tb.sv]
// ----------------------------------------------------------------------------
// cascaded_balance_pid_tb: self-checking bench for the cascaded balance controller
// A short table of hand-picked samples runs first. Seven gain settings follow,
// each with about a hundred and twenty samples, mostly from a clean control
// trajectory and partly random noise.
// A local model of the outer and inner loops predicts the result beats that the
// table does not give, and the beats are compared in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module cascaded_balance_pid_tb;

	localparam int PERIOD_MS   = 100;
	localparam int LATENCY     = 18;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 120;

	typedef logic signed [95:0] big_t;

	localparam big_t BAND_Q8   = 1280;
	localparam big_t MUL_LIM   = big_t'(1) <<< 53;
	localparam big_t DRIVE_CAP = big_t'(100) <<< 24;
	localparam big_t DRIVE_TOP = 25600;

	typedef struct packed {
		logic signed [11:0] tilt;
		logic signed [31:0] pos;
		logic [31:0]        now;
		logic signed [7:0]  tvel;
		logic signed [31:0] tpos;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [23:0] offset;
	} result_t;

	typedef struct {
		sample_t s;
		bit      known;
		result_t want;
	} row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [11:0] tilt_sample = '0;
	logic signed [31:0] wheel_position = '0;
	logic [31:0]        now_ms = '0;
	logic signed [7:0]  target_velocity = '0;
	logic signed [31:0] goal_position = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] drive_command;
	logic signed [23:0] tilt_offset;

	// Register copy and loop state of the local model.
	logic [23:0]        reg_file [8];
	logic [31:0]        outer_stamp, inner_stamp;
	logic signed [31:0] last_pos, last_vel, vel_err, accel, vel_sum;
	logic signed [47:0] tilt_sum;
	logic signed [39:0] last_err, err_step;

	result_t            command_q [$];
	int                 mismatches = 0;
	int                 send_pct = 0;
	int                 recv_pct = 0;
	logic [31:0]        track_now = '0;
	int                 track_pos = 0;
	logic signed [23:0] last_offset = '0;

	// Hand-picked samples. The first four leave all loop state at zero, so
	// their results follow directly from the default gains.
	row_t plan [18] = '{
		'{'{0, 0, 0, 0, 0}, 1'b1, '{0, 0}},
		'{'{1800, 0, 0, 0, 0}, 1'b1, '{-25600, 0}},
		'{'{-1800, 0, 0, 0, 0}, 1'b1, '{25600, 0}},
		'{'{0, 0, 100, 0, 0}, 1'b1, '{0, 0}},
		'{'{0, 1000, 101, 0, 0}, 1'b0, '{0, 0}},
		'{'{0, 1000, 150, 5, 1000}, 1'b0, '{0, 0}},
		'{'{3, 1050, 202, 5, 1100}, 1'b0, '{0, 0}},
		'{'{-2, 1100, 303, -3, 1100}, 1'b0, '{0, 0}},
		'{'{2047, 0, 304, 127, 0}, 1'b0, '{0, 0}},
		'{'{-2048, 0, 305, -128, 0}, 1'b0, '{0, 0}},
		'{'{0, 32'h7FFF_FFFF, 500, 64, 32'h8000_0000}, 1'b0, '{0, 0}},
		'{'{0, 32'h8000_0000, 700, -64, 32'h7FFF_FFFF}, 1'b0, '{0, 0}},
		'{'{0, 32'h7FFF_FFFF, 900, 0, 0}, 1'b0, '{0, 0}},
		'{'{100, 0, 32'hFFFF_FFF0, 0, 0}, 1'b0, '{0, 0}},
		'{'{100, 10, 32'h0000_0060, 0, 0}, 1'b0, '{0, 0}},
		'{'{0, 20, 32'hFFFF_FFFF, 0, 0}, 1'b0, '{0, 0}},
		'{'{0, 20, 32'h0000_0063, 0, 0}, 1'b0, '{0, 0}},
		'{'{1, 20, 32'h0000_0065, 0, 0}, 1'b0, '{0, 0}}
	};

	cascaded_balance_pid #(
		.UPDATE_PERIOD_MS(PERIOD_MS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.tilt_sample    (tilt_sample),
		.wheel_position (wheel_position),
		.now_ms         (now_ms),
		.target_velocity(target_velocity),
		.goal_position  (goal_position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_command  (drive_command),
		.tilt_offset    (tilt_offset)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic big_t clip(big_t x, int w);
		big_t hi, lo;
		hi = (big_t'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	function automatic big_t gain(cbp_pkg::reg_idx_t r);
		return big_t'($signed(reg_file[r]));
	endfunction

	function automatic void reset_model();
		foreach (reg_file[r])
			reg_file[r] = '0;
		reg_file[cbp_pkg::REG_TILT_KP]     = 24'd183501;
		reg_file[cbp_pkg::REG_POSITION_KP] = 24'd393;
		reg_file[cbp_pkg::REG_VELOCITY_KI] = 24'd66;
		reg_file[cbp_pkg::REG_VELOCITY_KD] = 24'd98304;
		reg_file[cbp_pkg::REG_ACCEL_GAIN]  = 24'd32768;
		outer_stamp = '0;
		inner_stamp = '0;
		last_pos = '0;
		last_vel = '0;
		vel_err = '0;
		accel = '0;
		vel_sum = '0;
		tilt_sum = '0;
		last_err = '0;
		err_step = '0;
	endfunction

	// One control step: outer loop to tilt offset, inner loop to drive.
	function automatic result_t balance_step(sample_t s);
		big_t tilt, pos, tpos, vel, sum, offset, err, ki_term, drive;
		logic [31:0] dt;
		result_t r;
		tilt = $signed(s.tilt);
		pos  = $signed(s.pos);
		tpos = $signed(s.tpos);
		dt = s.now - outer_stamp;
		if (dt > PERIOD_MS) begin
			vel = clip(pos - last_pos, 32);
			accel = 32'(clip(vel - last_vel, 32));
			vel_err = 32'(clip(big_t'($signed(s.tvel)) - vel, 32));
			last_pos = pos[31:0];
			last_vel = vel[31:0];
			outer_stamp = s.now;
			sum = big_t'(vel_sum) * 65536
				+ big_t'(vel_err) * gain(cbp_pkg::REG_VELOCITY_KI);
			// Signed division truncates toward zero.
			vel_sum = 32'(clip(sum / 65536, 32));
		end
		sum = gain(cbp_pkg::REG_POSITION_KP) * (tpos - pos)
			+ gain(cbp_pkg::REG_VELOCITY_KD) * big_t'(vel_err)
			+ big_t'(vel_sum) * 65536 + gain(cbp_pkg::REG_ACCEL_GAIN) * big_t'(accel);
		offset = clip((sum + 128) >>> 8, 24);

		err = big_t'($signed(reg_file[cbp_pkg::REG_ANGLE_SETPOINT][11:0])) * 256
			+ offset - tilt * 256;
		if (err < BAND_Q8 && err > -BAND_Q8)
			tilt_sum = 48'(clip(big_t'(tilt_sum) + err, 48));
		else
			tilt_sum = '0;
		dt = s.now - inner_stamp;
		if (dt > PERIOD_MS) begin
			err_step = 40'(err - big_t'(last_err));
			last_err = err[39:0];
			inner_stamp = s.now;
		end
		ki_term = gain(cbp_pkg::REG_TILT_KI) * big_t'(tilt_sum);
		if (ki_term > MUL_LIM)
			ki_term = MUL_LIM;
		else if (ki_term < -MUL_LIM)
			ki_term = -MUL_LIM;
		sum = gain(cbp_pkg::REG_TILT_KP) * err + ki_term
			+ gain(cbp_pkg::REG_TILT_KD) * big_t'(err_step);
		if (sum > DRIVE_CAP)
			sum = DRIVE_CAP;
		else if (sum < -DRIVE_CAP)
			sum = -DRIVE_CAP;
		drive = (sum + 32768) >>> 16;
		if (drive > DRIVE_TOP)
			drive = DRIVE_TOP;
		r.drive  = drive[15:0];
		r.offset = offset[23:0];
		return r;
	endfunction

	// Clean samples follow a plausible trajectory with the tilt held near the
	// current target, so the inner integral band is entered often.
	function automatic sample_t random_sample(bit clean);
		sample_t s;
		int lean;
		if (!clean) begin
			s.tilt = 12'($urandom);
			s.pos  = $urandom;
			s.now  = $urandom;
			s.tvel = 8'($urandom);
			s.tpos = $urandom;
			return s;
		end
		if ($urandom_range(0, 9) == 0)
			track_now = track_now + $urandom_range(100, 101);
		else
			track_now = track_now + $urandom_range(1, 160);
		track_pos = track_pos + int'($urandom_range(0, 120)) - 60;
		lean = int'($signed(reg_file[cbp_pkg::REG_ANGLE_SETPOINT][11:0]))
			+ int'(last_offset >>> 8) + int'($urandom_range(0, 16)) - 8;
		s.tilt = lean[11:0];
		s.pos  = track_pos;
		s.now  = track_now;
		s.tvel = 8'(int'($urandom_range(0, 128)) - 64);
		s.tpos = track_pos + int'($urandom_range(0, 6000)) - 3000;
		return s;
	endfunction

	task automatic take_sample(sample_t s, bit known, result_t want);
		result_t got;
		if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		tilt_sample     <= s.tilt;
		wheel_position  <= s.pos;
		now_ms          <= s.now;
		target_velocity <= s.tvel;
		goal_position   <= s.tpos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = balance_step(s);
		last_offset = got.offset;
		command_q.push_back(known ? want : got);
	endtask

	// Hold the sender off until every result beat has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (command_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_phase(int phase);
		logic [23:0] vals [8];
		int r;
		for (r = 0; r < 8; r++)
			vals[r] = 24'($urandom);
		case (phase)
			1: begin
				vals[cbp_pkg::REG_ANGLE_SETPOINT] = 24'($urandom_range(0, 40) - 20);
				vals[cbp_pkg::REG_TILT_KP]        = 24'd183501;
				vals[cbp_pkg::REG_TILT_KI]        = 24'($urandom_range(1000, 300000));
				vals[cbp_pkg::REG_TILT_KD]        = 24'($urandom_range(0, 2000000));
				vals[cbp_pkg::REG_POSITION_KP]    = 24'd393;
				vals[cbp_pkg::REG_VELOCITY_KI]    = 24'd66;
				vals[cbp_pkg::REG_VELOCITY_KD]    = 24'd98304;
				vals[cbp_pkg::REG_ACCEL_GAIN]     = 24'd32768;
			end
			2: begin
				for (r = 0; r < 8; r++)
					vals[r] = 24'h7F_FFFF;
				vals[cbp_pkg::REG_ANGLE_SETPOINT] = 24'd1800;
			end
			3: begin
				for (r = 0; r < 8; r++)
					vals[r] = 24'h80_0000;
				vals[cbp_pkg::REG_ANGLE_SETPOINT] = 24'hFF_F8F8;
			end
			5: begin
				for (r = 0; r < 8; r++)
					vals[r] = 24'($urandom_range(0, 1 << 21) - (1 << 20));
				vals[cbp_pkg::REG_ANGLE_SETPOINT] = 24'($urandom_range(0, 3600) - 1800);
			end
			6: begin
				vals[cbp_pkg::REG_POSITION_KP] = '0;
				vals[cbp_pkg::REG_VELOCITY_KI] = '0;
				vals[cbp_pkg::REG_VELOCITY_KD] = '0;
				vals[cbp_pkg::REG_ACCEL_GAIN]  = '0;
			end
			default: begin
			end
		endcase
		for (r = 0; r < 8; r++) begin
			cfg_write <= 1'b1;
			cfg_index <= cbp_pkg::reg_idx_t'(r);
			cfg_data  <= vals[r];
			reg_file[r] = vals[r];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (command_q.size() == 0) begin
				$display("%0t: result beat with no sample waiting: drive %0d offset %0d",
					$time, drive_command, tilt_offset);
				mismatches++;
			end else begin
				want = command_q.pop_front();
				if (drive_command !== want.drive) begin
					$display("%0t: drive_command expected %0d got %0d",
						$time, $signed(want.drive), drive_command);
					mismatches++;
				end
				if (tilt_offset !== want.offset) begin
					$display("%0t: tilt_offset expected %0d got %0d",
						$time, $signed(want.offset), tilt_offset);
					mismatches++;
				end
			end
		end
	end

	// Ends the run when no beat moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int i, n, phase;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(plan); i++)
			take_sample(plan[i].s, plan[i].known, plan[i].want);

		for (phase = 0; phase < 7; phase++) begin
			if (phase != 0) begin
				settle();
				load_phase(phase);
			end
			case (phase % 4)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 51; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 51; end
				default: begin send_pct = 19; recv_pct = 19; end
			endcase
			// Start each trajectory shortly before the timestamp wraps.
			track_now = 32'd0 - $urandom_range(0, 8000);
			track_pos = $urandom;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					settle();
				take_sample(random_sample($urandom_range(0, 99) < 80), 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
